// File: rtl/sgn_pkg.sv
// ----------------------------------------------------------------------------
// sgn_pkg
// Shared types and constants of the Sobel gradient / non-maximum suppression block.
// ----------------------------------------------------------------------------
package sgn_pkg;

   localparam int MAX_WIDTH_DEFAULT = 2048;

   localparam int GRAY_W  = 8;
   localparam int MAG_W   = 11;
   localparam int DIR_W   = 2;
   localparam int CFG_W   = 12;
   localparam int ROW_W   = 13;   // row counter runs two rows past the frame
   localparam int SUM_W   = 10;   // one side of the Sobel kernel, at most 1020
   localparam int SQ_W    = 20;
   localparam int RAD_W   = 22;
   localparam int ROOT_W  = 11;
   localparam int REM_W   = 12;
   localparam int STEP_W  = 4;
   localparam int SQRT_STEPS = 11;
   localparam int CSR_IDX_W  = 2;

   localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd640;
   localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd480;

   localparam logic [CSR_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

   localparam logic [DIR_W-1:0] DIR_0   = 2'd0;
   localparam logic [DIR_W-1:0] DIR_45  = 2'd1;
   localparam logic [DIR_W-1:0] DIR_90  = 2'd2;
   localparam logic [DIR_W-1:0] DIR_135 = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_GRAD,
      ST_SQUARE,
      ST_SUM,
      ST_ROOT,
      ST_MAG,
      ST_NMS
   } sgn_state_type;

   typedef struct packed {
      logic start;
      logic done;
   } sgn_sqrt_ctl_type;

endpackage

// File: rtl/sgn_isqrt.sv
// ----------------------------------------------------------------------------
// sgn_isqrt
// Digit-by-digit integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module sgn_isqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [sgn_pkg::RAD_W-1:0]     radicand,
   output logic                          done,
   output logic [sgn_pkg::ROOT_W-1:0]    root
);

   logic [sgn_pkg::RAD_W-1:0]  rad_ff;
   logic [sgn_pkg::REM_W-1:0]  rem_ff;
   logic [sgn_pkg::ROOT_W-1:0] root_ff;
   logic [sgn_pkg::STEP_W-1:0] cnt_ff;
   logic                       busy_ff;
   logic                       done_ff;
   logic [sgn_pkg::REM_W+1:0]  rem_in;
   logic [sgn_pkg::REM_W+1:0]  trial;
   logic                       take;

   always_comb begin
      rem_in = {rem_ff, rad_ff[sgn_pkg::RAD_W-1 -: 2]};
      trial  = (sgn_pkg::REM_W+2)'({root_ff, 2'b01});
      take   = (rem_in >= trial);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == sgn_pkg::STEP_W'(sgn_pkg::SQRT_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         rad_ff <= {rad_ff[sgn_pkg::RAD_W-3:0], 2'b00};
         if (take) begin
            rem_ff  <= sgn_pkg::REM_W'(rem_in - trial);
            root_ff <= {root_ff[sgn_pkg::ROOT_W-2:0], 1'b1};
         end else begin
            rem_ff  <= sgn_pkg::REM_W'(rem_in);
            root_ff <= {root_ff[sgn_pkg::ROOT_W-2:0], 1'b0};
         end
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// File: rtl/sobel_gradient_nms.sv
// ----------------------------------------------------------------------------
// sobel_gradient_nms
// 3x3 Sobel gradient, magnitude, quantized direction and non-maximum suppression.
// ----------------------------------------------------------------------------
// Gray pixels enter in raster order, one request each; once the pipeline has
// filled, every request that is not dropped returns one result for the pixel
// 2*W+2 positions back (W = frame_width clamped to 3..MAX_WIDTH, H = frame_height
// raised to 3). Flush requests (tuser=1) after the last pixel drain the frame; a
// flush that arrives mid-frame is taken and dropped. A pixel request runs through
// one read-modify-write of the gray line memory, squaring, the 11-step square
// root, a read-modify-write of the magnitude line memory and suppression. The
// result register lets the next request in while a result waits. Both line
// memories are indexed by column and need no clearing. A write to the width or
// height register restarts the frame.
// ----------------------------------------------------------------------------
module sobel_gradient_nms #(
   parameter int MAX_WIDTH = sgn_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,   // [7:0] gray
   input  logic [0:0]                        req_tuser,   // [0] func (1 = flush)
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [23:0]                       rsp_tdata,   // [10:0] nms_magnitude,
                                                          // [21:11] grad_magnitude,
                                                          // [23:22] direction
   output logic                              rsp_tlast,   // last pixel of frame
   input  logic                              csr_we,
   input  logic [sgn_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [sgn_pkg::CFG_W-1:0]         csr_wdata
);

   localparam int XW = $clog2(MAX_WIDTH);        // column index
   localparam int CW = $clog2(MAX_WIDTH + 1);    // width value
   localparam int GE = 2 * sgn_pkg::GRAY_W;
   localparam int ME = 2 * sgn_pkg::MAG_W + sgn_pkg::DIR_W;

   // registers and frame counters
   logic [sgn_pkg::CFG_W-1:0] fw_ff, fh_ff;
   logic [XW-1:0]             xt_ff, xe_ff;
   logic [sgn_pkg::ROW_W-1:0] yt_ff;
   logic [sgn_pkg::CFG_W-1:0] ye_ff;

   sgn_pkg::sgn_state_type state_ff, state_in;

   // line memories: gray {row t-w, row t-2w}, magnitude {mag t-w, dir t-w, mag t-2w}
   logic [GE-1:0] gmem [MAX_WIDTH];
   logic [ME-1:0] mmem [MAX_WIDTH];
   logic [GE-1:0] gq_ff;
   logic [ME-1:0] mq_ff;

   // 3x3 windows, index 0 is the oldest column
   logic [sgn_pkg::GRAY_W-1:0] gtop_ff [3];
   logic [sgn_pkg::GRAY_W-1:0] gmid_ff [3];
   logic [sgn_pkg::GRAY_W-1:0] gbot_ff [3];
   logic [sgn_pkg::MAG_W-1:0]  mtop_ff [3];
   logic [sgn_pkg::MAG_W-1:0]  mmid_ff [3];
   logic [sgn_pkg::MAG_W-1:0]  mbot_ff [3];
   logic [sgn_pkg::DIR_W-1:0]  dmid_ff [3];

   logic [sgn_pkg::GRAY_W-1:0] gray_ff;
   logic [sgn_pkg::SQ_W-1:0]   axsq_ff, aysq_ff;
   logic [sgn_pkg::SUM_W:0]    axy_ff;
   logic                       same_ff, zero_ff;
   logic [sgn_pkg::RAD_W-1:0]  s_ff;
   logic [sgn_pkg::MAG_W-1:0]  mag_new_ff;
   logic [sgn_pkg::DIR_W-1:0]  dir_new_ff;

   logic                       rsp_valid_ff;
   logic [23:0]                rsp_data_ff;
   logic                       rsp_last_ff;

   // control strobes
   logic accept, in_frame, work, out_free, emit, item_done;
   logic grad_en, sq_en, mag_en;
   sgn_pkg::sgn_sqrt_ctl_type sq_ctl;
   logic [sgn_pkg::ROOT_W-1:0] root;

   // effective frame size
   logic [CW-1:0]             eff_w, w_last;
   logic [sgn_pkg::CFG_W-1:0] eff_h;

   always_comb begin
      if (fw_ff < 12'd3) begin
         eff_w = CW'(3);
      end else if (32'(fw_ff) > MAX_WIDTH) begin
         eff_w = CW'(MAX_WIDTH);
      end else begin
         eff_w = CW'(fw_ff);
      end
      w_last = eff_w - 1'b1;
      eff_h  = (fh_ff < 12'd3) ? 12'd3 : fh_ff;
   end

   // position bookkeeping; t is the newest request, m the gradient, e the result
   logic m_int, e_int, e_last;
   logic [sgn_pkg::ROW_W-1:0] h_ext;

   always_comb begin
      h_ext    = sgn_pkg::ROW_W'(eff_h);
      in_frame = (yt_ff < h_ext);
      emit     = (yt_ff > sgn_pkg::ROW_W'(2)) ||
                 (yt_ff == sgn_pkg::ROW_W'(2) && xt_ff >= XW'(2));
      m_int    = (xt_ff >= XW'(2)) && (yt_ff >= sgn_pkg::ROW_W'(2)) && in_frame;
      e_int    = (xe_ff >= XW'(1)) && (CW'(xe_ff) < w_last) &&
                 (ye_ff >= 12'd1) && (ye_ff < eff_h - 12'd1);
      e_last   = (CW'(xe_ff) == w_last) && (ye_ff == eff_h - 12'd1);
   end

   assign accept   = req_tvalid && req_tready;
   assign work     = accept && !(in_frame && req_tuser[0]);
   assign out_free = !rsp_valid_ff || rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sgn_pkg::ST_IDLE:   if (work) state_in = sgn_pkg::ST_GRAD;
         sgn_pkg::ST_GRAD:   state_in = sgn_pkg::ST_SQUARE;
         sgn_pkg::ST_SQUARE: state_in = sgn_pkg::ST_SUM;
         sgn_pkg::ST_SUM:    state_in = sgn_pkg::ST_ROOT;
         sgn_pkg::ST_ROOT:   if (sq_ctl.done) state_in = sgn_pkg::ST_MAG;
         sgn_pkg::ST_MAG:    state_in = sgn_pkg::ST_NMS;
         sgn_pkg::ST_NMS:    if (!emit || out_free) state_in = sgn_pkg::ST_IDLE;
         default:            state_in = sgn_pkg::ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_tready   = 1'b0;
      grad_en      = 1'b0;
      sq_en        = 1'b0;
      sq_ctl.start = 1'b0;
      mag_en       = 1'b0;
      item_done    = 1'b0;
      case (state_ff)
         sgn_pkg::ST_IDLE:   req_tready   = 1'b1;
         sgn_pkg::ST_GRAD:   grad_en      = 1'b1;
         sgn_pkg::ST_SQUARE: sq_en        = 1'b1;
         sgn_pkg::ST_SUM:    sq_ctl.start = 1'b1;
         sgn_pkg::ST_MAG:    mag_en       = 1'b1;
         sgn_pkg::ST_NMS:    item_done    = !emit || out_free;
         default:            req_tready   = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sgn_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // configuration and frame counters
   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff <= sgn_pkg::WIDTH_RESET;
         fh_ff <= sgn_pkg::HEIGHT_RESET;
         xt_ff <= '0;
         yt_ff <= '0;
         xe_ff <= '0;
         ye_ff <= '0;
      end else if (csr_we && (csr_index == sgn_pkg::REG_FRAME_WIDTH ||
                              csr_index == sgn_pkg::REG_FRAME_HEIGHT)) begin
         if (csr_index == sgn_pkg::REG_FRAME_WIDTH) begin
            fw_ff <= csr_wdata;
         end else begin
            fh_ff <= csr_wdata;
         end
         xt_ff <= '0;
         yt_ff <= '0;
         xe_ff <= '0;
         ye_ff <= '0;
      end else if (item_done) begin
         if (emit && e_last) begin
            xt_ff <= '0;
            yt_ff <= '0;
            xe_ff <= '0;
            ye_ff <= '0;
         end else begin
            if (CW'(xt_ff) == w_last) begin
               xt_ff <= '0;
               yt_ff <= yt_ff + 1'b1;
            end else begin
               xt_ff <= xt_ff + 1'b1;
            end
            if (emit) begin
               if (CW'(xe_ff) == w_last) begin
                  xe_ff <= '0;
                  ye_ff <= ye_ff + 1'b1;
               end else begin
                  xe_ff <= xe_ff + 1'b1;
               end
            end
         end
      end
   end

   // line memories: read when a request is taken as work, written back later in the same item
   always_ff @(posedge clock) begin
      if (work) begin
         gq_ff <= gmem[xt_ff];
      end
      if (grad_en) begin
         gmem[xt_ff] <= {gray_ff, gq_ff[GE-1 -: sgn_pkg::GRAY_W]};
      end
   end

   always_ff @(posedge clock) begin
      if (work) begin
         mq_ff <= mmem[xt_ff];
      end
      if (mag_en) begin
         mmem[xt_ff] <= {mag_new_ff, dir_new_ff, mq_ff[ME-1 -: sgn_pkg::MAG_W]};
      end
   end

   // Sobel sums from the gray window
   logic [sgn_pkg::SUM_W-1:0] gxp, gxn, gyp, gyn, ax, ay;

   always_comb begin
      gxp = sgn_pkg::SUM_W'(gtop_ff[2]) + sgn_pkg::SUM_W'({gmid_ff[2], 1'b0})
          + sgn_pkg::SUM_W'(gbot_ff[2]);
      gxn = sgn_pkg::SUM_W'(gtop_ff[0]) + sgn_pkg::SUM_W'({gmid_ff[0], 1'b0})
          + sgn_pkg::SUM_W'(gbot_ff[0]);
      gyp = sgn_pkg::SUM_W'(gtop_ff[0]) + sgn_pkg::SUM_W'({gtop_ff[1], 1'b0})
          + sgn_pkg::SUM_W'(gtop_ff[2]);
      gyn = sgn_pkg::SUM_W'(gbot_ff[0]) + sgn_pkg::SUM_W'({gbot_ff[1], 1'b0})
          + sgn_pkg::SUM_W'(gbot_ff[2]);
      ax  = (gxp >= gxn) ? gxp - gxn : gxn - gxp;
      ay  = (gyp >= gyn) ? gyp - gyn : gyn - gyp;
   end

   // direction from exact integer tests: s = (|gx|+|gy|)^2
   logic [sgn_pkg::DIR_W-1:0] dir;

   always_comb begin
      if (zero_ff || s_ff < sgn_pkg::RAD_W'({axsq_ff, 1'b0})) begin
         dir = sgn_pkg::DIR_0;
      end else if (s_ff < sgn_pkg::RAD_W'({aysq_ff, 1'b0})) begin
         dir = sgn_pkg::DIR_90;
      end else if (same_ff) begin
         dir = sgn_pkg::DIR_45;
      end else begin
         dir = sgn_pkg::DIR_135;
      end
   end

   sgn_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_ctl.start),
      .radicand (sgn_pkg::RAD_W'(axsq_ff) + sgn_pkg::RAD_W'(aysq_ff)),
      .done     (sq_ctl.done),
      .root     (root)
   );

   // datapath
   always_ff @(posedge clock) begin
      if (work) begin
         gray_ff <= in_frame ? req_tdata : '0;
      end
      if (grad_en) begin
         gtop_ff[0] <= gtop_ff[1];
         gtop_ff[1] <= gtop_ff[2];
         gtop_ff[2] <= gq_ff[sgn_pkg::GRAY_W-1:0];
         gmid_ff[0] <= gmid_ff[1];
         gmid_ff[1] <= gmid_ff[2];
         gmid_ff[2] <= gq_ff[GE-1 -: sgn_pkg::GRAY_W];
         gbot_ff[0] <= gbot_ff[1];
         gbot_ff[1] <= gbot_ff[2];
         gbot_ff[2] <= gray_ff;
      end
      if (sq_en) begin
         axsq_ff <= ax * ax;
         aysq_ff <= ay * ay;
         axy_ff  <= (sgn_pkg::SUM_W+1)'(ax) + (sgn_pkg::SUM_W+1)'(ay);
         zero_ff <= (ax == '0) && (ay == '0);
         // gx > 0 and gy > 0 agree
         same_ff <= ((gxp > gxn) == (gyp > gyn));
      end
      if (sq_ctl.start) begin
         s_ff <= axy_ff * axy_ff;
      end
      if (state_ff == sgn_pkg::ST_ROOT && sq_ctl.done) begin
         mag_new_ff <= m_int ? root : '0;
         dir_new_ff <= m_int ? dir : sgn_pkg::DIR_0;
      end
      if (mag_en) begin
         mtop_ff[0] <= mtop_ff[1];
         mtop_ff[1] <= mtop_ff[2];
         mtop_ff[2] <= mq_ff[sgn_pkg::MAG_W-1:0];
         mmid_ff[0] <= mmid_ff[1];
         mmid_ff[1] <= mmid_ff[2];
         mmid_ff[2] <= mq_ff[ME-1 -: sgn_pkg::MAG_W];
         mbot_ff[0] <= mbot_ff[1];
         mbot_ff[1] <= mbot_ff[2];
         mbot_ff[2] <= mag_new_ff;
         dmid_ff[0] <= dmid_ff[1];
         dmid_ff[1] <= dmid_ff[2];
         dmid_ff[2] <= mq_ff[sgn_pkg::MAG_W +: sgn_pkg::DIR_W];
      end
   end

   // suppression: center of the magnitude window against its two neighbors
   logic [sgn_pkg::MAG_W-1:0] n1, n2, nms;

   always_comb begin
      case (dmid_ff[1])
         sgn_pkg::DIR_0: begin
            n1 = mmid_ff[0];
            n2 = mmid_ff[2];
         end
         sgn_pkg::DIR_45: begin
            n1 = mtop_ff[2];
            n2 = mbot_ff[0];
         end
         sgn_pkg::DIR_90: begin
            n1 = mtop_ff[1];
            n2 = mbot_ff[1];
         end
         default: begin
            n1 = mtop_ff[0];
            n2 = mbot_ff[2];
         end
      endcase
      nms = (e_int && mmid_ff[1] >= n1 && mmid_ff[1] >= n2) ? mmid_ff[1] : '0;
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (item_done && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (item_done && emit) begin
         rsp_data_ff <= {dmid_ff[1], mmid_ff[1], nms};
         rsp_last_ff <= e_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// File: rtl/sgn_checker.sv
// ----------------------------------------------------------------------------
// sgn_checker
// Port-level checks of the Sobel gradient block, bound to the top level.
// ----------------------------------------------------------------------------
module sgn_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [0:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // a pixel request always starts multi-cycle work
   a_pixel_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !req_tuser[0] |=> !req_tready)
      else $error("ready stayed high after a pixel request");

   // a new result only comes out of the busy phase
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tready))
      else $error("result appeared without work in progress");

   // suppressed magnitude is either the gradient magnitude or zero
   a_nms_value: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[10:0] == rsp_tdata[21:11] || rsp_tdata[10:0] == 11'd0))
      else $error("suppressed magnitude out of range");

endmodule

bind sobel_gradient_nms sgn_checker u_sgn_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Sobel gradient / non-maximum suppression block.
// ----------------------------------------------------------------------------
// Streams gray frames in raster order, followed by flush requests that drain
// the two-row pipeline. A scoreboard class predicts each result as its request
// is accepted and compares the results in order. Frame sizes change between
// frames through the register port, while the block is idle. Both handshakes
// idle at random, and one long receiver hold-off fills the block up.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import sgn_pkg::*;

   localparam int GRAY_RING = 2 * MAX_WIDTH_DEFAULT + 3;
   localparam int DIR_RING  = MAX_WIDTH_DEFAULT + 2;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE = 2'd2;   // not decoded by the block
   localparam bit FUNC_PIXEL = 1'b0;
   localparam bit FUNC_FLUSH = 1'b1;
   localparam int IDLE_LIMIT  = 5000;   // cycles without any handshake
   localparam int SETTLE      = 40;     // > per-request latency of the block
   localparam int HOLD_CYCLES = 600;

   typedef struct {
      bit [MAG_W-1:0] nms;
      bit [MAG_W-1:0] grad;
      bit [DIR_W-1:0] dir;
      bit             last;
   } edge_pixel_t;

   // Predicts the suppressed gradient stream and checks it in order.
   class gradient_scoreboard;
      bit [GRAY_W-1:0] gray_ring[GRAY_RING];
      int unsigned     mag_ring[GRAY_RING];
      bit [DIR_W-1:0]  dir_ring[DIR_RING];
      bit [CFG_W-1:0]  width_reg;
      bit [CFG_W-1:0]  height_reg;
      int unsigned     raster_pos;
      int unsigned     errors;
      edge_pixel_t     pending_px[$];

      function new();
         foreach (gray_ring[i]) gray_ring[i] = '0;
         foreach (mag_ring[i]) mag_ring[i] = 0;
         foreach (dir_ring[i]) dir_ring[i] = DIR_0;
         width_reg  = WIDTH_RESET;
         height_reg = HEIGHT_RESET;
         raster_pos = 0;
         errors     = 0;
      endfunction

      function void report(string msg);
         $display("ERROR @%0t: %s", $time, msg);
         errors++;
      endfunction

      function int unsigned eff_width();
         if (width_reg < 3) return 3;
         if (width_reg > MAX_WIDTH_DEFAULT) return MAX_WIDTH_DEFAULT;
         return width_reg;
      endfunction

      function int unsigned eff_height();
         return (height_reg < 3) ? 3 : height_reg;
      endfunction

      function int gray_at(int unsigned i);
         return int'(gray_ring[i % GRAY_RING]);
      endfunction

      function int unsigned floor_root(int unsigned v);
         int unsigned r, b;
         r = 0;
         b = 1 << 30;
         while (b > v) b >>= 2;
         while (b != 0) begin
            if (v >= r + b) begin
               v -= r + b;
               r = (r >> 1) + b;
            end else begin
               r >>= 1;
            end
            b >>= 2;
         end
         return r;
      endfunction

      // Magnitude and direction of raster position m, stored in the rings.
      function void grade_pixel(int unsigned m, int unsigned w, int unsigned h);
         int unsigned x, y, up, dn, ax, ay, sq, mag;
         int gx, gy;
         bit [DIR_W-1:0] dir;
         x = m % w;
         y = m / w;
         mag = 0;
         dir = DIR_0;
         if (x >= 1 && x + 1 < w && y >= 1 && y + 1 < h) begin
            up = m - w;
            dn = m + w;
            gx = -gray_at(up - 1) + gray_at(up + 1) - 2 * gray_at(m - 1)
                 + 2 * gray_at(m + 1) - gray_at(dn - 1) + gray_at(dn + 1);
            gy = gray_at(up - 1) + 2 * gray_at(up) + gray_at(up + 1)
                 - gray_at(dn - 1) - 2 * gray_at(dn) - gray_at(dn + 1);
            ax = (gx < 0) ? -gx : gx;
            ay = (gy < 0) ? -gy : gy;
            sq = (ax + ay) * (ax + ay);
            mag = floor_root(ax * ax + ay * ay);
            if ((ax == 0 && ay == 0) || sq < 2 * ax * ax) dir = DIR_0;
            else if (sq < 2 * ay * ay) dir = DIR_90;
            else if ((gx > 0) == (gy > 0)) dir = DIR_45;
            else dir = DIR_135;
         end
         mag_ring[m % GRAY_RING] = mag;
         dir_ring[m % DIR_RING]  = dir;
      endfunction

      function void write_reg(bit [CSR_IDX_W-1:0] idx, bit [CFG_W-1:0] val);
         if (idx == REG_FRAME_WIDTH) width_reg = val;
         else if (idx == REG_FRAME_HEIGHT) height_reg = val;
         else return;
         raster_pos = 0;
      endfunction

      function void note_request(bit func, bit [GRAY_W-1:0] gray);
         int unsigned w, h, total, lat, t, e, x, y, mag, m1, m2;
         bit [GRAY_W-1:0] g;
         edge_pixel_t px;
         w = eff_width();
         h = eff_height();
         total = w * h;
         lat = 2 * w + 2;
         t = raster_pos;
         g = '0;
         if (t < total) begin
            if (func == FUNC_FLUSH) return;   // flush mid-frame: dropped
            g = gray;
         end
         gray_ring[t % GRAY_RING] = g;
         if (t >= w + 1 && t - w - 1 < total) grade_pixel(t - w - 1, w, h);
         if (t < lat) begin
            raster_pos = t + 1;
            return;
         end
         e = t - lat;
         x = e % w;
         y = e / w;
         mag = mag_ring[e % GRAY_RING];
         px.dir = dir_ring[e % DIR_RING];
         px.grad = mag;
         px.nms = '0;
         px.last = (e + 1 >= total);
         if (x >= 1 && x + 1 < w && y >= 1 && y + 1 < h) begin
            case (px.dir)
               DIR_0: begin
                  m1 = mag_ring[(e - 1) % GRAY_RING];
                  m2 = mag_ring[(e + 1) % GRAY_RING];
               end
               DIR_45: begin
                  m1 = mag_ring[(e - w + 1) % GRAY_RING];
                  m2 = mag_ring[(e + w - 1) % GRAY_RING];
               end
               DIR_90: begin
                  m1 = mag_ring[(e - w) % GRAY_RING];
                  m2 = mag_ring[(e + w) % GRAY_RING];
               end
               default: begin
                  m1 = mag_ring[(e - w - 1) % GRAY_RING];
                  m2 = mag_ring[(e + w + 1) % GRAY_RING];
               end
            endcase
            if (mag >= m1 && mag >= m2) px.nms = mag;
         end
         raster_pos = px.last ? 0 : t + 1;
         pending_px.push_back(px);
      endfunction

      function void check_result(bit [23:0] data, bit last);
         edge_pixel_t px;
         if (pending_px.size() == 0) begin
            report($sformatf("unexpected result data=%h last=%0d", data, last));
            return;
         end
         px = pending_px.pop_front();
         if (data[10:0] != px.nms)
            report($sformatf("nms_magnitude %0d, want %0d", data[10:0], px.nms));
         if (data[21:11] != px.grad)
            report($sformatf("grad_magnitude %0d, want %0d", data[21:11], px.grad));
         if (data[23:22] != px.dir)
            report($sformatf("direction %0d, want %0d", data[23:22], px.dir));
         if (last != px.last)
            report($sformatf("last %0d, want %0d", last, px.last));
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [7:0]           req_tdata = '0;   // [7:0] gray
   logic [0:0]           req_tuser = '0;   // [0] func (1 = flush)
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [23:0]          rsp_tdata;        // [10:0] nms, [21:11] grad, [23:22] direction
   logic                 rsp_tlast;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0]     csr_wdata = '0;

   gradient_scoreboard edge_sb = new();

   bit hold_rsp = 0;     // stimulus asks for one long receiver hold-off
   bit free_flow = 0;    // no idling on either side
   int unsigned pixels_sent = 0;

   sobel_gradient_nms i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // mostly short gaps, now and then a long one
   function automatic int gap_len();
      int r;
      if (free_flow) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Result side: random stalls, plus the long hold-off when asked.
   initial begin
      int stall;
      stall = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) edge_sb.check_result(rsp_tdata, rsp_tlast);
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 0;
         end
         if (stall > 0) begin
            stall--;
            rsp_tready <= 1'b0;
         end else if (!free_flow && $urandom_range(0, 7) == 0) begin
            stall = gap_len();
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog: counts cycles with no handshake at all.
   initial begin
      int idle;
      idle = 0;
      forever begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle = 0;
         else idle++;
         if (idle >= IDLE_LIMIT) begin
            $display("Watchdog: no progress for %0d cycles", IDLE_LIMIT);
            $display("Mismatches found");
            $finish;
         end
      end
   end

   // One request; valid stays up into the next request when there is no gap.
   task automatic push_item(bit func, bit [7:0] gray);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= gray;
      do @(posedge clock); while (!req_tready);
      edge_sb.note_request(func, gray);
      gap = gap_len();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (edge_sb.pending_px.size() != 0) @(posedge clock);
   endtask

   // Register writes only with the block idle; requests that return no result may still
   // be in flight after the last result, hence the settle time.
   task automatic csr_write(bit [CSR_IDX_W-1:0] idx, bit [CFG_W-1:0] val);
      wait_drained();
      repeat (SETTLE) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      edge_sb.write_reg(idx, val);
      csr_we <= 1'b0;
   endtask

   function automatic bit [7:0] pick_gray(int style, int unsigned x, int unsigned y);
      case (style)
         0: return $urandom_range(0, 255);
         1: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
         2: return (x > y) ? 8'hFF : 8'h00;   // diagonal edge
         default: return 8'((x * 37 + y * 11) ^ $urandom_range(0, 15));
      endcase
   endfunction

   // Frame of raw register values; keep < full count to cut it short.
   task automatic run_frame(bit [CFG_W-1:0] w_raw, bit [CFG_W-1:0] h_raw, int style,
                            bit noise, int unsigned keep, bit pause_mid);
      int unsigned w, h, total, p;
      w = (w_raw < 3) ? 3 : (w_raw > MAX_WIDTH_DEFAULT) ? MAX_WIDTH_DEFAULT : w_raw;
      h = (h_raw < 3) ? 3 : h_raw;
      total = w * h;
      csr_write(REG_FRAME_WIDTH, w_raw);
      csr_write(REG_FRAME_HEIGHT, h_raw);
      if (keep > total) keep = total;
      for (p = 0; p < keep; p++) begin
         if (noise && $urandom_range(0, 24) == 0) push_item(FUNC_FLUSH, $urandom_range(0, 255));
         if (pause_mid && p == keep / 2) wait_drained();
         push_item(FUNC_PIXEL, pick_gray(style, p % w, p / w));
         pixels_sent++;
      end
      if (keep < total) return;   // cut short: next write restarts the frame
      // drain; a pixel here counts as a flush
      for (p = 0; p < 2 * w + 2; p++) begin
         push_item($urandom_range(0, 5) != 0 ? FUNC_FLUSH : FUNC_PIXEL,
                   $urandom_range(0, 255));
         pixels_sent++;
      end
   endtask

   initial begin
      int n, style;
      bit [CFG_W-1:0] w_raw, h_raw;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // a few pixels under the reset frame size, then restarted
      repeat (4) push_item(FUNC_PIXEL, $urandom_range(0, 255));

      // directed: 3x3 frame, extreme grays, mid-frame flush, pixel while draining
      csr_write(REG_FRAME_WIDTH, 12'd3);
      csr_write(REG_FRAME_HEIGHT, 12'd3);
      csr_write(REG_SPARE, 12'd7);   // unmapped index, no restart
      push_item(FUNC_PIXEL, 8'h00);
      push_item(FUNC_PIXEL, 8'hFF);
      push_item(FUNC_FLUSH, 8'hA5);
      push_item(FUNC_PIXEL, 8'hFF);
      push_item(FUNC_PIXEL, 8'h00);
      push_item(FUNC_PIXEL, 8'h80);
      push_item(FUNC_PIXEL, 8'hFF);
      push_item(FUNC_PIXEL, 8'h00);
      push_item(FUNC_PIXEL, 8'h00);
      push_item(FUNC_PIXEL, 8'hFF);
      push_item(FUNC_PIXEL, 8'h5A);
      repeat (7) push_item(FUNC_FLUSH, 8'h00);
      // width below range clamps to 3, strong edges
      run_frame(12'd0, 12'd4, 2, 0, '1, 0);
      run_frame(12'd5, 12'd0, 1, 0, '1, 0);

      // random frames; the first ones carry the hold-off and the pause
      n = 0;
      while (pixels_sent < 1900) begin
         free_flow = ($urandom_range(0, 5) == 0);
         style = $urandom_range(0, 3);
         if ($urandom_range(0, 19) == 0) begin
            w_raw = $urandom_range(0, 2);
            h_raw = $urandom_range(0, 2);
         end else if ($urandom_range(0, 9) == 0) begin
            w_raw = $urandom_range(17, 80);
            h_raw = $urandom_range(3, 5);
         end else begin
            w_raw = $urandom_range(3, 16);
            h_raw = $urandom_range(3, 8);
         end
         if (n == 2) begin
            free_flow = 0;
            w_raw = 16;
            h_raw = 8;
            hold_rsp = 1;   // sender keeps going until the block stalls it
         end
         run_frame(w_raw, h_raw, style, $urandom_range(0, 3) == 0,
                   ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40) : '1, n == 3);
         n++;
      end

      // extremes: width above range clamps to the maximum, ring wraps;
      // tallest frame cut short
      free_flow = 0;
      run_frame(12'd4095, 12'd3, 0, 0, '1, 0);
      run_frame(12'd3, 12'd4095, 1, 1, 60, 0);
      run_frame(12'd2048, 12'd3, 3, 0, 300, 0);
      run_frame(12'd3, 12'd3, 0, 0, '1, 0);

      wait_drained();
      repeat (50) @(posedge clock);
      if (edge_sb.errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
